// ----- rtl/core/lsp_pkg.sv -----
// Shared constants, types and control structs for the linear prime sieve.
`timescale 1ns / 1ps

package lsp_pkg;

   // Sieve sizing
   localparam int MAX_LIMIT   = 65535;
   localparam int PRIME_SLOTS = 8192;

   // Derived widths
   localparam int STORE_DEPTH = MAX_LIMIT + 1;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int LIST_AW     = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1;
   localparam int COUNT_W     = $clog2(PRIME_SLOTS + 1);
   localparam int PROD_W      = 2 * STORE_AW;

   // Fixed port field widths
   localparam int KIND_W = 2;
   localparam int VAL_W  = 16;

   typedef logic [STORE_AW-1:0] addr_type;
   typedef logic [LIST_AW-1:0]  list_addr_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [PROD_W-1:0]   prod_type;
   typedef logic [VAL_W-1:0]    val_type;

   // Request kinds; the unused code is answered with an error
   typedef enum logic [KIND_W-1:0] {
      KIND_BUILD = 2'd0,
      KIND_SPF   = 2'd1,
      KIND_RANK  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_RD_SPF,
      ST_CHK_SPF,
      ST_LOOP_RD,
      ST_LOOP_MUL,
      ST_LOOP_WR,
      ST_NEXT,
      ST_Q_WAIT,
      ST_FINISH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic start_build;
      logic clear_step;
      logic chk_spf;
      logic loop_mul;
      logic mark;
      logic k_adv;
      logic i_adv;
      logic build_done;
      logic q_issue;
      logic q_capture;
      logic out_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      kind_type kind;
      logic     err;
      logic     q_small;
      logic     lim_small;
      logic     clear_last;
      logic     k_done;
      logic     prod_over;
      logic     p_is_spf;
      logic     i_last;
      logic     out_free;
   } stat_type;

endpackage

// ----- rtl/core/lsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]    rd_addr_chk;

   assign rd_addr_chk = rd_addr;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr_chk];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/lsp_ctrl.sv -----
// Sequencer for build sweeps, sieve walk and queries of the linear prime sieve.
`timescale 1ns / 1ps

module lsp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lsp_pkg::stat_type stat,
   output lsp_pkg::cmd_type  cmd
);

   lsp_pkg::state_type state_ff;
   lsp_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lsp_pkg::ST_IDLE: begin
            if (req_valid) state_in = lsp_pkg::ST_DECODE;
         end
         lsp_pkg::ST_DECODE: begin
            case (stat.kind)
               lsp_pkg::KIND_BUILD: begin
                  state_in = stat.lim_small ? lsp_pkg::ST_FINISH : lsp_pkg::ST_CLEAR;
               end
               lsp_pkg::KIND_SPF: begin
                  state_in = (stat.err || stat.q_small) ? lsp_pkg::ST_FINISH
                                                        : lsp_pkg::ST_Q_WAIT;
               end
               lsp_pkg::KIND_RANK: begin
                  state_in = stat.err ? lsp_pkg::ST_FINISH : lsp_pkg::ST_Q_WAIT;
               end
               default: begin
                  state_in = lsp_pkg::ST_FINISH;
               end
            endcase
         end
         lsp_pkg::ST_CLEAR: begin
            if (stat.clear_last) state_in = lsp_pkg::ST_RD_SPF;
         end
         lsp_pkg::ST_RD_SPF: begin
            state_in = lsp_pkg::ST_CHK_SPF;
         end
         lsp_pkg::ST_CHK_SPF: begin
            state_in = lsp_pkg::ST_LOOP_RD;
         end
         lsp_pkg::ST_LOOP_RD: begin
            state_in = stat.k_done ? lsp_pkg::ST_NEXT : lsp_pkg::ST_LOOP_MUL;
         end
         lsp_pkg::ST_LOOP_MUL: begin
            state_in = lsp_pkg::ST_LOOP_WR;
         end
         lsp_pkg::ST_LOOP_WR: begin
            state_in = (stat.prod_over || stat.p_is_spf) ? lsp_pkg::ST_NEXT
                                                         : lsp_pkg::ST_LOOP_RD;
         end
         lsp_pkg::ST_NEXT: begin
            state_in = stat.i_last ? lsp_pkg::ST_FINISH : lsp_pkg::ST_RD_SPF;
         end
         lsp_pkg::ST_Q_WAIT: begin
            state_in = lsp_pkg::ST_FINISH;
         end
         lsp_pkg::ST_FINISH: begin
            if (stat.out_free) state_in = lsp_pkg::ST_IDLE;
         end
         default: begin
            state_in = lsp_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         lsp_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         lsp_pkg::ST_DECODE: begin
            case (stat.kind)
               lsp_pkg::KIND_BUILD: begin
                  cmd.start_build = 1'b1;
                  cmd.build_done  = stat.lim_small;
               end
               lsp_pkg::KIND_SPF: begin
                  cmd.q_issue = !stat.err && !stat.q_small;
               end
               lsp_pkg::KIND_RANK: begin
                  cmd.q_issue = !stat.err;
               end
               default: begin
                  cmd.q_issue = 1'b0;
               end
            endcase
         end
         lsp_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         lsp_pkg::ST_CHK_SPF: begin
            cmd.chk_spf = 1'b1;
         end
         lsp_pkg::ST_LOOP_MUL: begin
            cmd.loop_mul = 1'b1;
         end
         lsp_pkg::ST_LOOP_WR: begin
            cmd.mark  = !stat.prod_over;
            cmd.k_adv = !stat.prod_over && !stat.p_is_spf;
         end
         lsp_pkg::ST_NEXT: begin
            cmd.build_done = stat.i_last;
            cmd.i_adv      = !stat.i_last;
         end
         lsp_pkg::ST_Q_WAIT: begin
            cmd.q_capture = 1'b1;
         end
         lsp_pkg::ST_FINISH: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- rtl/core/lsp_dp.sv -----
// Datapath of the linear prime sieve: counters, factor store, prime list, result register.
`timescale 1ns / 1ps

module lsp_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  lsp_pkg::cmd_type                  cmd,
   output lsp_pkg::stat_type                 stat,
   input  logic [lsp_pkg::KIND_W-1:0]        req_kind,
   input  logic [lsp_pkg::VAL_W-1:0]         req_limit,
   input  logic [lsp_pkg::VAL_W-1:0]         req_query,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [lsp_pkg::VAL_W-1:0]         rsp_answer,
   output logic [lsp_pkg::COUNT_W-1:0]       rsp_prime_count,
   output logic                              rsp_status
);

   // Latched request
   lsp_pkg::kind_type   kind_ff, kind_in;
   lsp_pkg::val_type    query_ff, query_in;
   lsp_pkg::addr_type   lim_ff, lim_in;

   // Sieve state
   lsp_pkg::addr_type   bound_ff, bound_in;
   lsp_pkg::count_type  cnt_ff, cnt_in;

   // Walk registers
   lsp_pkg::addr_type   clr_ff, clr_in;
   lsp_pkg::addr_type   i_ff, i_in;
   lsp_pkg::count_type  k_ff, k_in;
   lsp_pkg::addr_type   spf_ff, spf_in;
   lsp_pkg::addr_type   p_ff, p_in;
   lsp_pkg::prod_type   prod_ff, prod_in;
   lsp_pkg::val_type    answer_ff, answer_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   lsp_pkg::val_type    rsp_answer_ff, rsp_answer_in;
   lsp_pkg::count_type  rsp_count_ff, rsp_count_in;
   logic                rsp_status_ff, rsp_status_in;

   // Memory ports
   logic                     st_wr_en;
   lsp_pkg::addr_type        st_wr_addr, st_wr_data, st_rd_addr, st_rd_data;
   logic                     ls_wr_en;
   lsp_pkg::list_addr_type   ls_wr_addr, ls_rd_addr;
   lsp_pkg::addr_type        ls_rd_data;

   logic                     spf_zero;
   logic                     list_room;
   logic                     err;
   lsp_pkg::addr_type        lim_sat;

   assign spf_zero  = (st_rd_data == '0);
   assign list_room = (lsp_pkg::prod_type'(cnt_ff) < lsp_pkg::prod_type'(lsp_pkg::PRIME_SLOTS));

   // Clamp the build limit to the store size
   assign lim_sat = (lsp_pkg::prod_type'(req_limit) > lsp_pkg::prod_type'(lsp_pkg::MAX_LIMIT))
                    ? lsp_pkg::addr_type'(lsp_pkg::MAX_LIMIT)
                    : lsp_pkg::addr_type'(req_limit);

   // Error status of the latched request
   always_comb begin
      case (kind_ff)
         lsp_pkg::KIND_BUILD: begin
            err = 1'b0;
         end
         lsp_pkg::KIND_SPF: begin
            err = (bound_ff == '0)
               || (lsp_pkg::prod_type'(query_ff) > lsp_pkg::prod_type'(bound_ff));
         end
         lsp_pkg::KIND_RANK: begin
            err = (bound_ff == '0)
               || (lsp_pkg::prod_type'(query_ff) >= lsp_pkg::prod_type'(cnt_ff))
               || (lsp_pkg::prod_type'(query_ff)
                   >= lsp_pkg::prod_type'(lsp_pkg::PRIME_SLOTS));
         end
         default: begin
            err = 1'b1;
         end
      endcase
   end

   // Status to the controller
   always_comb begin
      stat.kind       = kind_ff;
      stat.err        = err;
      stat.q_small    = (query_ff < lsp_pkg::val_type'(2));
      stat.lim_small  = (lim_ff < lsp_pkg::addr_type'(2));
      stat.clear_last = (clr_ff == lim_ff);
      stat.k_done     = (k_ff >= cnt_ff);
      stat.prod_over  = (prod_ff > lsp_pkg::prod_type'(lim_ff));
      stat.p_is_spf   = (p_ff == spf_ff);
      stat.i_last     = (i_ff == lim_ff);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Factor store ports: sweep clear, prime self-mark, composite mark
   always_comb begin
      st_wr_en   = cmd.clear_step || (cmd.chk_spf && spf_zero) || cmd.mark;
      st_wr_addr = lsp_pkg::addr_type'(prod_ff[lsp_pkg::STORE_AW-1:0]);
      st_wr_data = p_ff;
      if (cmd.clear_step) begin
         st_wr_addr = clr_ff;
         st_wr_data = '0;
      end else if (cmd.chk_spf) begin
         st_wr_addr = i_ff;
         st_wr_data = i_ff;
      end
      st_rd_addr = cmd.q_issue ? lsp_pkg::addr_type'(query_ff) : i_ff;
   end

   // Prime list ports: append new prime, read rank k or queried rank
   always_comb begin
      ls_wr_en   = cmd.chk_spf && spf_zero && list_room;
      ls_wr_addr = cnt_ff[lsp_pkg::LIST_AW-1:0];
      ls_rd_addr = cmd.q_issue ? lsp_pkg::list_addr_type'(query_ff)
                               : k_ff[lsp_pkg::LIST_AW-1:0];
   end

   lsp_ram #(
      .WIDTH (lsp_pkg::STORE_AW),
      .DEPTH (lsp_pkg::STORE_DEPTH)
   ) u_factor_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   lsp_ram #(
      .WIDTH (lsp_pkg::STORE_AW),
      .DEPTH (lsp_pkg::PRIME_SLOTS)
   ) u_prime_list (
      .clock   (clock),
      .wr_en   (ls_wr_en),
      .wr_addr (ls_wr_addr),
      .wr_data (i_ff),
      .rd_addr (ls_rd_addr),
      .rd_data (ls_rd_data)
   );

   // Next values
   always_comb begin
      kind_in       = kind_ff;
      query_in      = query_ff;
      lim_in        = lim_ff;
      bound_in      = bound_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      spf_in        = spf_ff;
      p_in          = p_ff;
      prod_in       = prod_ff;
      answer_in     = answer_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      // Capture the request on transfer
      if (cmd.load_req) begin
         kind_in   = lsp_pkg::kind_type'(req_kind);
         query_in  = req_query;
         lim_in    = lim_sat;
         answer_in = '0;
      end

      // Start a build: sweep from two, walk from two, empty list
      if (cmd.start_build) begin
         clr_in = lsp_pkg::addr_type'(2);
         i_in   = lsp_pkg::addr_type'(2);
         cnt_in = '0;
      end
      if (cmd.clear_step) clr_in = clr_ff + lsp_pkg::addr_type'(1);

      // New prime when the store entry is still empty
      if (cmd.chk_spf) begin
         spf_in = spf_zero ? i_ff : st_rd_data;
         k_in   = '0;
         if (spf_zero && list_room) cnt_in = cnt_ff + lsp_pkg::count_type'(1);
      end

      // Register the product before the compare
      if (cmd.loop_mul) begin
         p_in    = ls_rd_data;
         prod_in = lsp_pkg::prod_type'(i_ff) * lsp_pkg::prod_type'(ls_rd_data);
      end

      if (cmd.k_adv) k_in = k_ff + lsp_pkg::count_type'(1);
      if (cmd.i_adv) i_in = i_ff + lsp_pkg::addr_type'(1);
      if (cmd.build_done) bound_in = lim_ff;

      if (cmd.q_capture) begin
         answer_in = (kind_ff == lsp_pkg::KIND_SPF) ? lsp_pkg::val_type'(st_rd_data)
                                                    : lsp_pkg::val_type'(ls_rd_data);
      end

      // Output register: load a result or drop one taken
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_answer_in = err ? '0 : answer_ff;
         rsp_count_in  = cnt_ff;
         rsp_status_in = err;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bound_ff     <= bound_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      query_ff      <= query_in;
      lim_ff        <= lim_in;
      clr_ff        <= clr_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      spf_ff        <= spf_in;
      p_ff          <= p_in;
      prod_ff       <= prod_in;
      answer_ff     <= answer_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_answer      = rsp_answer_ff;
   assign rsp_prime_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ----- rtl/core/linear_prime_sieve.sv -----
// Query: decode, then read and capture the answer (skipped for an error or a factor query
// of zero or one); the next request is taken the cycle after the result loads.
// Build: clear the store from two to the limit; for each value, mark it prime if unmarked,
// then mark its products with listed primes up to its smallest factor and within the limit.
// The result sits in an output register; the next request is taken while it waits.
// Synchronous active-high reset zeroes prime count and built bound; no store sweep follows.
`timescale 1ns / 1ps

module linear_prime_sieve (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lsp_pkg::KIND_W-1:0]    req_kind,
   input  logic [lsp_pkg::VAL_W-1:0]     req_limit,
   input  logic [lsp_pkg::VAL_W-1:0]     req_query,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lsp_pkg::VAL_W-1:0]     rsp_answer,
   output logic [lsp_pkg::COUNT_W-1:0]   rsp_prime_count,
   output logic                          rsp_status
);

   lsp_pkg::cmd_type  cmd;
   lsp_pkg::stat_type stat;

   lsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lsp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_kind),
      .req_limit       (req_limit),
      .req_query       (req_query),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_answer      (rsp_answer),
      .rsp_prime_count (rsp_prime_count),
      .rsp_status      (rsp_status)
   );

endmodule

// ----- rtl/core/lsp_checker.sv -----
// Port-level checks of the linear prime sieve, bound to the top level.
`timescale 1ns / 1ps

module lsp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [lsp_pkg::KIND_W-1:0]    req_kind,
   input logic [lsp_pkg::VAL_W-1:0]     req_limit,
   input logic [lsp_pkg::VAL_W-1:0]     req_query,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lsp_pkg::VAL_W-1:0]     rsp_answer,
   input logic [lsp_pkg::COUNT_W-1:0]   rsp_prime_count,
   input logic                          rsp_status
);

   // No result is left over from before reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A waiting request holds until its transfer
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_kind)
         && $stable(req_limit) && $stable(req_query))
      else $error("waiting request changed");

   // A stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_answer)
         && $stable(rsp_prime_count) && $stable(rsp_status))
      else $error("stalled result changed");

   // An error result carries no answer
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_answer == '0)
      else $error("error result with nonzero answer");

   // No factor or prime is ever one, and the count stays within the list
   a_answer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_answer != lsp_pkg::val_type'(1)
         && rsp_prime_count <= lsp_pkg::count_type'(lsp_pkg::PRIME_SLOTS))
      else $error("answer or prime count out of range");

endmodule

bind linear_prime_sieve lsp_checker u_lsp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_kind        (req_kind),
   .req_limit       (req_limit),
   .req_query       (req_query),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_answer      (rsp_answer),
   .rsp_prime_count (rsp_prime_count),
   .rsp_status      (rsp_status)
);
